// ----- rtl/core/bf5_pkg.sv -----
// Shared constants and types for the 5x5 bilateral filter core.
// No dependencies; imported by the divider cells, the divider and the top level.
package bf5_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int WINDOW     = 5;
  localparam int HALF_WIN   = WINDOW / 2;

  // pixel store spans more than 4*MAX_WIDTH+WINDOW pixels, power-of-two deep
  localparam int STORE_AW   = $clog2(4 * MAX_WIDTH + WINDOW);
  localparam int DIM_W      = 9;
  localparam int COUNT_W    = 17;
  localparam int WEIGHT_W   = 16;
  localparam int SUM_W      = 28;
  localparam int WSUM_W     = 20;
  localparam int QUO_W      = 16;
  localparam int DVD_W      = SUM_W + 8;

  localparam logic [WEIGHT_W-1:0] ONE_Q15 = 16'd32768;

  localparam logic [1:0] OP_PIXEL = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_SW_D1  = 3'd2;
  localparam logic [2:0] REG_SW_D2  = 3'd3;
  localparam logic [2:0] REG_SW_D4  = 3'd4;
  localparam logic [2:0] REG_SW_D5  = 3'd5;
  localparam logic [2:0] REG_SW_D8  = 3'd6;

  // one step of the restoring divider, handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic [WSUM_W-1:0] rem;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
    logic [WSUM_W-1:0] dvs;
  } div_stage_t;

  function automatic logic [WEIGHT_W-1:0] sat_q15(input logic [WEIGHT_W-1:0] v);
    return (v > ONE_Q15) ? ONE_Q15 : v;
  endfunction

endpackage

// ----- rtl/core/bf5_div_cell.sv -----
// One restoring division step: takes a partial remainder, emits one quotient bit.
// Depends on bf5_pkg.
module bf5_div_cell import bf5_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  div_stage_t stage_in,
  output div_stage_t stage_out
);

  logic [WSUM_W:0] trial;
  logic            fits;

  always_comb begin
    trial = {stage_in.rem, stage_in.low[QUO_W-1]};
    fits  = (trial >= {1'b0, stage_in.dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
    end else begin
      stage_out.valid <= stage_in.valid;
    end
    stage_out.rem <= fits ? WSUM_W'(trial - {1'b0, stage_in.dvs}) : trial[WSUM_W-1:0];
    stage_out.low <= {stage_in.low[QUO_W-2:0], 1'b0};
    stage_out.quo <= {stage_in.quo[QUO_W-2:0], fits};
    stage_out.dvs <= stage_in.dvs;
  end

endmodule

// ----- rtl/core/bf5_divider.sv -----
// Chain of division cells, one quotient bit per cell and per cycle.
// Depends on bf5_pkg and bf5_div_cell.
module bf5_divider import bf5_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DVD_W-1:0]  dividend,
  input  logic [WSUM_W-1:0] divisor,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  div_stage_t chain [QUO_W+1];

  // quotient is known to fit 16 bits, so the high part is already below the divisor
  always_comb begin
    chain[0].valid = start;
    chain[0].rem   = dividend[DVD_W-1:QUO_W];
    chain[0].low   = dividend[QUO_W-1:0];
    chain[0].quo   = '0;
    chain[0].dvs   = divisor;
  end

  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    bf5_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_in  (chain[i]),
      .stage_out (chain[i+1])
    );
  end

  assign done     = chain[QUO_W].valid;
  assign quotient = chain[QUO_W].quo;

endmodule

// ----- rtl/core/bilateral_filter_5x5_core.sv -----
// Top level of the 5x5 bilateral filter: registers, pixel store, range table, sequencer.
// Depends on bf5_pkg and bf5_divider.
//
//  channel   | handshake                 | payload
//  s_axis    | s_axis_tvalid/tready      | tdata pixel/index/value, tuser opcode
//  m_axis    | m_axis_tvalid/tready      | tdata filtered value, tlast end of frame
//  apb       | psel/penable/pwrite/pready| paddr, pwdata, prdata
//
// A word that gives no result is taken while the sequencer stays idle. A word that releases
// a result leads, up to the next accept, through S_CENT and S_CCAP to fetch the centre,
// then S_TRD, S_TRNG, S_TMUL and S_TACC per window tap through the single store port and
// range table port, S_DIV to start the divide, S_DWAIT through the divider chain (skipped
// on a zero weight sum) and S_OUT to load the result register, held while m_axis stalls.
// Reset is synchronous; store and range table are not cleared. The result register
// lets the next word be taken while a result waits on m_axis.
module bilateral_filter_5x5_core import bf5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // pixel_value[7:0], table_index[15:8], table_value[31:16]
  input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // filtered_value[15:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CENT  = 4'd1;
  localparam logic [3:0] S_CCAP  = 4'd2;
  localparam logic [3:0] S_TRD   = 4'd3;
  localparam logic [3:0] S_TRNG  = 4'd4;
  localparam logic [3:0] S_TMUL  = 4'd5;
  localparam logic [3:0] S_TACC  = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_DWAIT = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [2:0] TAP_LAST = 3'(WINDOW - 1);

  // configuration
  logic [DIM_W-1:0]    image_width, image_height;
  logic [WEIGHT_W-1:0] sw_d1, sw_d2, sw_d4, sw_d5, sw_d8;
  logic                cfg_wr;
  logic [2:0]          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
      sw_d1        <= 16'd28918;
      sw_d2        <= 16'd25520;
      sw_d4        <= 16'd19875;
      sw_d5        <= 16'd17539;
      sw_d8        <= 16'd12055;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH:  image_width  <= pwdata[DIM_W-1:0];
        REG_HEIGHT: image_height <= pwdata[DIM_W-1:0];
        REG_SW_D1:  sw_d1        <= pwdata[WEIGHT_W-1:0];
        REG_SW_D2:  sw_d2        <= pwdata[WEIGHT_W-1:0];
        REG_SW_D4:  sw_d4        <= pwdata[WEIGHT_W-1:0];
        REG_SW_D5:  sw_d5        <= pwdata[WEIGHT_W-1:0];
        REG_SW_D8:  sw_d8        <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = {23'd0, image_width};
      REG_HEIGHT: prdata = {23'd0, image_height};
      REG_SW_D1:  prdata = {16'd0, sw_d1};
      REG_SW_D2:  prdata = {16'd0, sw_d2};
      REG_SW_D4:  prdata = {16'd0, sw_d4};
      REG_SW_D5:  prdata = {16'd0, sw_d5};
      REG_SW_D8:  prdata = {16'd0, sw_d8};
      default:    prdata = '0;
    endcase
  end

  // effective geometry
  logic [DIM_W-1:0]   weff, heff;
  logic [COUNT_W-1:0] total;
  logic [9:0]         latency;
  logic [17:0]        area;

  always_comb begin
    if (image_width == '0)                        weff = 9'd1;
    else if (image_width > DIM_W'(MAX_WIDTH))     weff = DIM_W'(MAX_WIDTH);
    else                                          weff = image_width;
    if (image_height == '0)                       heff = 9'd1;
    else if (image_height > DIM_W'(MAX_HEIGHT))   heff = DIM_W'(MAX_HEIGHT);
    else                                          heff = image_height;
    area    = weff * heff;
    total   = area[COUNT_W-1:0];
    latency = {1'b0, weff} + {1'b0, weff} + 10'd2;
  end

  // input side
  logic [3:0]  state;
  logic        in_acc;
  logic [1:0]  opcode;
  logic [7:0]  pixel_value, table_index;
  logic [15:0] table_value;

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign opcode        = s_axis_tuser;
  assign pixel_value   = s_axis_tdata[7:0];
  assign table_index   = s_axis_tdata[15:8];
  assign table_value   = s_axis_tdata[31:16];

  logic [DIM_W-1:0]   rx_col, rx_row, out_col, out_row;
  logic [COUNT_W-1:0] rx_count, out_count, rx_inc, backlog;
  logic               all_in, pix_wr, emit;

  always_comb begin
    rx_inc  = rx_count + 1'b1;
    backlog = rx_inc - out_count;
    all_in  = (rx_count >= total);
    pix_wr  = in_acc && (opcode == OP_PIXEL) && !all_in;
    emit    = 1'b0;
    if (in_acc && (opcode == OP_PIXEL || opcode == OP_FLUSH)) begin
      if (all_in)                emit = (out_count < total);
      else if (opcode == OP_PIXEL) emit = (backlog > {7'd0, latency});
    end
  end

  // per-result job state
  logic [STORE_AW-1:0] job_k, row_addr;
  logic [DIM_W-1:0]    job_cx, job_cy;
  logic                job_eof;
  logic [2:0]          tx, ty;
  logic [7:0]          cpix, npix;
  logic                inimg;
  logic [WEIGHT_W-1:0] wt;
  logic [SUM_W-1:0]    sum;
  logic [WSUM_W-1:0]   wsum;
  logic [QUO_W-1:0]    result;

  logic frame_end;
  assign frame_end = ((out_count + 1'b1) >= total);

  always_ff @(posedge clk) begin
    if (rst || (cfg_wr && (cfg_idx == REG_WIDTH || cfg_idx == REG_HEIGHT))) begin
      rx_col <= '0; rx_row <= '0; rx_count <= '0;
      out_col <= '0; out_row <= '0; out_count <= '0;
    end else if (emit && frame_end) begin
      rx_col <= '0; rx_row <= '0; rx_count <= '0;
      out_col <= '0; out_row <= '0; out_count <= '0;
    end else begin
      if (pix_wr) begin
        rx_count <= rx_inc;
        if (rx_col + 1'b1 >= weff) begin
          rx_col <= '0;
          rx_row <= rx_row + 1'b1;
        end else begin
          rx_col <= rx_col + 1'b1;
        end
      end
      if (emit) begin
        out_count <= out_count + 1'b1;
        if (out_col + 1'b1 >= weff) begin
          out_col <= '0;
          out_row <= out_row + 1'b1;
        end else begin
          out_col <= out_col + 1'b1;
        end
      end
    end
  end

  // memories
  logic [7:0]          pix_mem [2**STORE_AW];
  logic [WEIGHT_W-1:0] rng_mem [256];
  logic [STORE_AW-1:0] rd_addr;
  logic [7:0]          rd_data, diff;
  logic [WEIGHT_W-1:0] rng_data;

  always_comb begin
    rd_addr = (state == S_CENT) ? job_k : STORE_AW'(row_addr + {{(STORE_AW-3){1'b0}}, tx});
    diff    = (rd_data > cpix) ? rd_data - cpix : cpix - rd_data;
  end

  always_ff @(posedge clk) begin
    if (pix_wr) pix_mem[rx_count[STORE_AW-1:0]] <= pixel_value;
    rd_data <= pix_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_acc && opcode == OP_LOAD) rng_mem[table_index] <= sat_q15(table_value);
    rng_data <= rng_mem[diff];
  end

  // spatial weight of the current tap, by squared distance
  logic [1:0]          ax, ay;
  logic [3:0]          d2;
  logic [WEIGHT_W-1:0] spat;

  always_comb begin
    ax = (tx >= 3'd2) ? 2'(tx - 3'd2) : 2'(3'd2 - tx);
    ay = (ty >= 3'd2) ? 2'(ty - 3'd2) : 2'(3'd2 - ty);
    d2 = {2'd0, ax} * {2'd0, ax} + {2'd0, ay} * {2'd0, ay};
    unique case (d2)
      4'd0:    spat = ONE_Q15;
      4'd1:    spat = sat_q15(sw_d1);
      4'd2:    spat = sat_q15(sw_d2);
      4'd4:    spat = sat_q15(sw_d4);
      4'd5:    spat = sat_q15(sw_d5);
      4'd8:    spat = sat_q15(sw_d8);
      default: spat = '0;
    endcase
  end

  logic [9:0]  nx_sum, ny_sum;
  logic [31:0] wprod;
  logic [23:0] pprod;

  always_comb begin
    nx_sum = {1'b0, job_cx} + {7'd0, tx};
    ny_sum = {1'b0, job_cy} + {7'd0, ty};
    wprod  = spat * sat_q15(rng_data);
    pprod  = npix * wt;
  end

  // divider
  logic             div_start, div_done;
  logic [QUO_W-1:0] quotient;

  assign div_start = (state == S_DIV) && (wsum != '0);

  bf5_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({sum, 8'd0}),
    .divisor  (wsum),
    .done     (div_done),
    .quotient (quotient)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)                                  m_axis_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (emit) state <= S_CENT;
        end
        S_CENT: state <= S_CCAP;
        S_CCAP: state <= S_TRD;
        S_TRD:  state <= S_TRNG;
        S_TRNG: state <= S_TMUL;
        S_TMUL: state <= S_TACC;
        S_TACC: begin
          if (tx == TAP_LAST && ty == TAP_LAST) state <= S_DIV;
          else                                  state <= S_TRD;
        end
        S_DIV: begin
          if (wsum == '0) state <= S_OUT;
          else            state <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) state <= S_OUT;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        job_k    <= out_count[STORE_AW-1:0];
        job_cx   <= out_col;
        job_cy   <= out_row;
        job_eof  <= frame_end;
        row_addr <= STORE_AW'(out_count[STORE_AW-1:0] - {weff, 1'b1} - 1'b1);
        tx       <= '0;
        ty       <= '0;
        sum      <= '0;
        wsum     <= '0;
      end
      S_CCAP: cpix <= rd_data;
      S_TRD: begin
        // tap lies in the image when 0 <= c+t-2 < size
        inimg <= (nx_sum >= 10'd2) && (nx_sum < {1'b0, weff} + 10'd2) &&
                 (ny_sum >= 10'd2) && (ny_sum < {1'b0, heff} + 10'd2);
      end
      S_TRNG: npix <= rd_data;
      S_TMUL: wt <= wprod[30:15];
      S_TACC: begin
        if (inimg) begin
          sum  <= sum + SUM_W'(pprod);
          wsum <= wsum + WSUM_W'(wt);
        end
        if (tx == TAP_LAST) begin
          tx       <= '0;
          ty       <= ty + 1'b1;
          row_addr <= STORE_AW'(row_addr + {{(STORE_AW-DIM_W){1'b0}}, weff});
        end else begin
          tx <= tx + 1'b1;
        end
      end
      S_DIV: begin
        if (wsum == '0) result <= {cpix, 8'd0};
      end
      S_DWAIT: begin
        if (div_done) result <= quotient;
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= result;
          m_axis_tlast <= job_eof;
        end
      end
      default: ;
    endcase
  end

endmodule
